// ===== design/dtfb_pkg.sv =====
`timescale 1ns / 1ps

package dtfb_pkg;

   // Frame limits
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int COORD_W        = 9;    // in-frame coordinates stay below 511
   localparam int DIM_W          = 13;   // holds any frame limit up to 4096

   // Queue depths
   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 2;

   // Field widths
   localparam int DEPTH_W = 32;
   localparam int RGB_W   = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Reset values of the frame size registers
   localparam logic [COORD_W-1:0] FRAME_DIM_RESET = 9'd256;

   // Item modes
   localparam logic [1:0] MODE_DRAW  = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CLEAR_RGB   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CLEAR_DEPTH = 2'd3;

   typedef enum logic [2:0] {
      OP_DRAW,
      OP_DRAW_TEST,
      OP_CLEAR,
      OP_READ,
      OP_OOB,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [COORD_W-1:0]   col;
      logic [COORD_W-1:0]   row;
      logic [DEPTH_W-1:0]   depth;
      logic [RGB_W-1:0]     rgb;
      logic                 clr_color;
      logic                 clr_depth;
   } cmd_type;

   typedef struct packed {
      logic [COORD_W-1:0]   act_w;
      logic [COORD_W-1:0]   act_h;
      logic [RGB_W-1:0]     clear_rgb;
      logic [DEPTH_W-1:0]   clear_depth;
   } cfg_type;

   typedef struct packed {
      logic [7:0] read_red;
      logic [7:0] read_green;
      logic [7:0] read_blue;
      logic       pixel_written;
      logic       out_of_bounds;
   } rsp_type;

endpackage

// ===== design/dtfb_fifo.sv =====
`timescale 1ns / 1ps

module dtfb_fifo #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] wr_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] rd_data,
   output logic              empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff;
   logic [PW-1:0]     rd_ptr_ff;
   logic [CW-1:0]     count_ff;
   logic              do_push;
   logic              do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== design/dtfb_front.sv =====
`timescale 1ns / 1ps

module dtfb_front #(
   parameter int MAX_WIDTH  = dtfb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = dtfb_pkg::DEF_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_data,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [1:0]            req_mode,
   input  logic signed [15:0]    req_x_pos,
   input  logic signed [15:0]    req_y_pos,
   input  logic [31:0]           req_depth_in,
   input  logic [7:0]            req_red_in,
   input  logic [7:0]            req_green_in,
   input  logic [7:0]            req_blue_in,
   input  logic                  req_use_depth_test,
   input  logic                  req_clear_color_sel,
   input  logic                  req_clear_depth_sel,
   output logic                  cmd_push,
   output dtfb_pkg::cmd_type     cmd,
   input  logic                  cmd_full,
   output dtfb_pkg::cfg_type     cfg
);

   import dtfb_pkg::*;

   logic [COORD_W-1:0] fw_ff;
   logic [COORD_W-1:0] fh_ff;
   logic [RGB_W-1:0]   clear_rgb_ff;
   logic [DEPTH_W-1:0] clear_depth_ff;
   logic [COORD_W-1:0] act_w;
   logic [COORD_W-1:0] act_h;
   logic signed [12:0] rx;
   logic signed [12:0] ry;
   logic signed [13:0] dy;
   logic               draw_in;
   logic               read_in;

   // 12.4 to integer, half away from zero
   function automatic logic signed [12:0] round_q4(input logic signed [15:0] v);
      logic [16:0] mag;
      logic [16:0] q;
      logic [12:0] qn;
      mag = v[15] ? (17'd0 - {1'b1, v}) : {1'b0, v};
      q   = (mag + 17'd8) >> 4;
      qn  = q[12:0];
      return v[15] ? $signed(13'd0 - qn) : $signed(qn);
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff          <= FRAME_DIM_RESET;
         fh_ff          <= FRAME_DIM_RESET;
         clear_rgb_ff   <= '0;
         clear_depth_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_FRAME_WIDTH:  fw_ff          <= csr_data[COORD_W-1:0];
            REG_FRAME_HEIGHT: fh_ff          <= csr_data[COORD_W-1:0];
            REG_CLEAR_RGB:    clear_rgb_ff   <= csr_data[RGB_W-1:0];
            REG_CLEAR_DEPTH:  clear_depth_ff <= csr_data[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   // Saturate the frame size to the store limits
   assign act_w = ({4'b0, fw_ff} > DIM_W'(MAX_WIDTH))  ? COORD_W'(MAX_WIDTH)  : fw_ff;
   assign act_h = ({4'b0, fh_ff} > DIM_W'(MAX_HEIGHT)) ? COORD_W'(MAX_HEIGHT) : fh_ff;

   assign cfg.act_w       = act_w;
   assign cfg.act_h       = act_h;
   assign cfg.clear_rgb   = clear_rgb_ff;
   assign cfg.clear_depth = clear_depth_ff;

   assign rx = round_q4(req_x_pos);
   assign ry = round_q4(req_y_pos);
   // flip y to a row index
   assign dy = $signed({5'b0, act_h}) - 14'sd1 - $signed({ry[12], ry});

   assign draw_in = !rx[12] && (rx < $signed({4'b0, act_w}))
                 && !dy[13] && (dy < $signed({5'b0, act_h}));
   assign read_in = !req_x_pos[15] && (req_x_pos < $signed({7'b0, act_w}))
                 && !req_y_pos[15] && (req_y_pos < $signed({7'b0, act_h}));

   always_comb begin
      cmd.depth     = req_depth_in;
      cmd.rgb       = {req_red_in, req_green_in, req_blue_in};
      cmd.clr_color = req_clear_color_sel;
      cmd.clr_depth = req_clear_depth_sel;
      cmd.col       = rx[COORD_W-1:0];
      cmd.row       = dy[COORD_W-1:0];
      case (req_mode)
         MODE_DRAW: begin
            if (!draw_in) begin
               cmd.op = OP_OOB;
            end else if (req_use_depth_test) begin
               cmd.op = OP_DRAW_TEST;
            end else begin
               cmd.op = OP_DRAW;
            end
         end
         MODE_CLEAR: begin
            cmd.op = OP_CLEAR;
         end
         MODE_READ: begin
            cmd.op  = read_in ? OP_READ : OP_OOB;
            cmd.col = req_x_pos[COORD_W-1:0];
            cmd.row = req_y_pos[COORD_W-1:0];
         end
         default: begin
            cmd.op = OP_NONE;
         end
      endcase
   end

   assign req_full = cmd_full;
   assign cmd_push = req_push && !cmd_full;

endmodule

// ===== design/dtfb_back.sv =====
`timescale 1ns / 1ps

module dtfb_back #(
   parameter int MAX_WIDTH  = dtfb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = dtfb_pkg::DEF_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dtfb_pkg::cfg_type     cfg,
   input  dtfb_pkg::cmd_type     cmd,
   input  logic                  cmd_empty,
   output logic                  cmd_pop,
   input  logic                  rsp_full,
   output logic                  rsp_push,
   output dtfb_pkg::rsp_type     rsp
);

   import dtfb_pkg::*;

   localparam int CW        = (MAX_WIDTH > 1)  ? $clog2(MAX_WIDTH)  : 1;
   localparam int RW        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int AW        = CW + RW;
   localparam int MEM_DEPTH = 1 << AW;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_APPLY,
      ST_SWEEP
   } state_type;

   state_type          state_ff;
   cmd_type            cmd_ff;
   logic [COORD_W-1:0] row_ff;
   logic [COORD_W-1:0] col_ff;
   logic               rsp_push_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   logic [RGB_W-1:0]   color_mem [MEM_DEPTH];
   logic [DEPTH_W-1:0] depth_mem [MEM_DEPTH];
   logic [RGB_W-1:0]   color_rd_ff;
   logic [DEPTH_W-1:0] depth_rd_ff;

   logic               start;
   logic               sweeping;
   logic               depth_win;
   logic               sweep_last;
   logic [AW-1:0]      mem_addr;
   logic               color_we;
   logic               depth_we;
   logic [RGB_W-1:0]   color_wdata;
   logic [DEPTH_W-1:0] depth_wdata;

   // One item in flight; the result queue has room once no push is pending
   assign start    = (state_ff == ST_IDLE) && !cmd_empty && !rsp_full && !rsp_push_ff;
   assign cmd_pop  = start;
   assign sweeping = (state_ff == ST_SWEEP);

   assign depth_win  = $signed(cmd_ff.depth) > $signed(depth_rd_ff);
   assign sweep_last = (col_ff == cfg.act_w - 1'b1) && (row_ff == cfg.act_h - 1'b1);

   assign mem_addr = sweeping ? {RW'(row_ff), CW'(col_ff)}
                              : {RW'(cmd_ff.row), CW'(cmd_ff.col)};

   assign color_wdata = sweeping ? cfg.clear_rgb   : cmd_ff.rgb;
   assign depth_wdata = sweeping ? cfg.clear_depth : cmd_ff.depth;

   assign color_we = (sweeping && cmd_ff.clr_color)
                  || ((state_ff == ST_APPLY)
                      && ((cmd_ff.op == OP_DRAW) || ((cmd_ff.op == OP_DRAW_TEST) && depth_win)));
   assign depth_we = (sweeping && cmd_ff.clr_depth)
                  || ((state_ff == ST_APPLY) && (cmd_ff.op == OP_DRAW_TEST) && depth_win);

   always_ff @(posedge clock) begin
      if (color_we) begin
         color_mem[mem_addr] <= color_wdata;
      end
      color_rd_ff <= color_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (depth_we) begin
         depth_mem[mem_addr] <= depth_wdata;
      end
      depth_rd_ff <= depth_mem[mem_addr];
   end

   // Result of the item in the apply step
   always_comb begin
      rsp_in = '0;
      case (cmd_ff.op)
         OP_DRAW: begin
            rsp_in.pixel_written = 1'b1;
         end
         OP_DRAW_TEST: begin
            rsp_in.pixel_written = depth_win;
         end
         OP_READ: begin
            rsp_in.read_red   = color_rd_ff[23:16];
            rsp_in.read_green = color_rd_ff[15:8];
            rsp_in.read_blue  = color_rd_ff[7:0];
         end
         OP_OOB: begin
            rsp_in.out_of_bounds = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rsp_push_ff <= 1'b0;
      end else begin
         rsp_push_ff <= (state_ff == ST_APPLY);
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  cmd_ff <= cmd;
                  row_ff <= '0;
                  col_ff <= '0;
                  if (cmd.op != OP_CLEAR) begin
                     state_ff <= ST_LOOKUP;
                  end else if ((cfg.act_w == '0) || (cfg.act_h == '0)) begin
                     state_ff <= ST_APPLY;
                  end else begin
                     state_ff <= ST_SWEEP;
                  end
               end
            end
            ST_LOOKUP: begin
               state_ff <= ST_APPLY;
            end
            ST_SWEEP: begin
               // advance across the row, then to the next row
               if (sweep_last) begin
                  state_ff <= ST_APPLY;
               end else if (col_ff == cfg.act_w - 1'b1) begin
                  col_ff <= '0;
                  row_ff <= row_ff + 1'b1;
               end else begin
                  col_ff <= col_ff + 1'b1;
               end
            end
            ST_APPLY: begin
               rsp_ff   <= rsp_in;
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_push = rsp_push_ff;
   assign rsp      = rsp_ff;

`ifndef ASSERT_OFF
   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push_ff |-> !rsp_full)
      else $error("result pushed into a full queue");

   a_sweep_in_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> ((col_ff < cfg.act_w) && (row_ff < cfg.act_h)))
      else $error("clear sweep left the active frame");

   a_written_is_draw: assert property (@(posedge clock) disable iff (reset)
      (rsp_push_ff && rsp_ff.pixel_written)
         |-> ((cmd_ff.op == OP_DRAW) || (cmd_ff.op == OP_DRAW_TEST)))
      else $error("pixel written flagged on an item that is not a draw");

   a_apply_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |=> ((state_ff == ST_IDLE) && rsp_push_ff))
      else $error("apply step did not hand over a result");
`endif

endmodule

// ===== design/depth_tested_frame_buffer.sv =====
`timescale 1ns / 1ps

// Channel   Ports                         Accept condition
// req       req_push / req_full + fields  req_push && !req_full
// rsp       rsp_pop / rsp_empty + fields  rsp_pop && !rsp_empty
// csr       csr_valid / csr_ready         csr_valid && csr_ready (ready is always high)
//
// Draw, read, out-of-frame and unused items pass through these steps in the back
// engine: pop, store read, compare/write, result push into the result queue.
// A clear sweeps the whole active frame, one pixel a cycle, then pushes a result.
// Reset clears control state only; store contents are undefined until a clear.
// The command queue (4 items) lets input run ahead of the engine; the result
// queue (2 items) holds finished results while the consumer stalls.

module depth_tested_frame_buffer #(
   parameter int MAX_WIDTH  = dtfb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = dtfb_pkg::DEF_MAX_HEIGHT
) (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   // items in
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_mode,
   input  logic signed [15:0] req_x_pos,
   input  logic signed [15:0] req_y_pos,
   input  logic signed [31:0] req_depth_in,
   input  logic [7:0]         req_red_in,
   input  logic [7:0]         req_green_in,
   input  logic [7:0]         req_blue_in,
   input  logic               req_use_depth_test,
   input  logic               req_clear_color_sel,
   input  logic               req_clear_depth_sel,
   // results out
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [7:0]         rsp_read_red,
   output logic [7:0]         rsp_read_green,
   output logic [7:0]         rsp_read_blue,
   output logic               rsp_pixel_written,
   output logic               rsp_out_of_bounds
);

   import dtfb_pkg::*;

   cmd_type cmd_wr;
   cmd_type cmd_rd;
   cfg_type cfg;
   rsp_type rsp_wr;
   rsp_type rsp_rd;
   logic    cmd_push;
   logic    cmd_full;
   logic    cmd_pop;
   logic    cmd_empty;
   logic    rsp_push;
   logic    rsp_full;

   // Front: hold the registers, round and flip coordinates, classify the item
   dtfb_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_mode            (req_mode),
      .req_x_pos           (req_x_pos),
      .req_y_pos           (req_y_pos),
      .req_depth_in        (req_depth_in),
      .req_red_in          (req_red_in),
      .req_green_in        (req_green_in),
      .req_blue_in         (req_blue_in),
      .req_use_depth_test  (req_use_depth_test),
      .req_clear_color_sel (req_clear_color_sel),
      .req_clear_depth_sel (req_clear_depth_sel),
      .cmd_push            (cmd_push),
      .cmd                 (cmd_wr),
      .cmd_full            (cmd_full),
      .cfg                 (cfg)
   );

   // Decouple classification from store access
   dtfb_fifo #(
      .DATA_W ($bits(cmd_type)),
      .DEPTH  (CMD_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd),
      .empty   (cmd_empty)
   );

   // Back: run the depth test, writes, reads and clear sweeps on the stores
   dtfb_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd_rd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_wr)
   );

   // Hold finished results until the consumer pops them
   dtfb_fifo #(
      .DATA_W ($bits(rsp_type)),
      .DEPTH  (RSP_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_wr),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_rd),
      .empty   (rsp_empty)
   );

   assign rsp_read_red      = rsp_rd.read_red;
   assign rsp_read_green    = rsp_rd.read_green;
   assign rsp_read_blue     = rsp_rd.read_blue;
   assign rsp_pixel_written = rsp_rd.pixel_written;
   assign rsp_out_of_bounds = rsp_rd.out_of_bounds;

endmodule
